### hdl/mlfqs_pkg.sv
// ----------------------------------------------------------------------------
// mlfqs_pkg
// Shared constants, types and fixed-point helpers for the scheduler block.
// ----------------------------------------------------------------------------
package mlfqs_pkg;

    localparam int MAX_THREADS      = 64;
    localparam int IDX_W            = 6;
    localparam int FRACTION_BITS    = 14;
    localparam int TICKS_PER_SECOND = 100;
    localparam int PRIORITY_HIGHEST = 63;
    localparam int PRIORITY_LOWEST  = 0;
    localparam int PRIORITY_PERIOD  = 4;
    localparam int LOAD_NUM         = 59;
    localparam int LOAD_DEN         = 60;
    localparam int DIV_W            = 40;
    localparam int CNT_W            = $clog2(DIV_W + 1);
    localparam int PROD_W           = 66;

    // x / d for 32-bit x as (x * ceil(2^37 / d)) >> 37
    localparam int RECIP_SHIFT = 37;
    localparam int QUO_W       = 64 - RECIP_SHIFT;
    localparam logic [31:0] TPS_RECIP =
        32'(((64'd1 << RECIP_SHIFT) + 64'(TICKS_PER_SECOND) - 64'd1) / 64'(TICKS_PER_SECOND));
    localparam logic [31:0] DEN_RECIP =
        32'(((64'd1 << RECIP_SHIFT) + 64'(LOAD_DEN) - 64'd1) / 64'(LOAD_DEN));

    localparam logic signed [PROD_W-1:0] FP_ONE  = PROD_W'(1) <<< FRACTION_BITS;
    localparam logic signed [PROD_W-1:0] FP_HALF = FP_ONE >>> 1;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_NICE   = 2'd1,
        CMD_CREATE = 2'd2,
        CMD_RETIRE = 2'd3
    } t_cmd;

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_EXE, S_PRA, S_PRB,
        S_MODT, S_MODQ, S_MODC, S_L1, S_L1R, S_L1Q, S_L2R, S_CD, S_CW,
        S_WA, S_WB, S_WC, S_CHKP, S_QA, S_QB,
        S_FRD, S_FM1, S_FM2, S_OUT
    } t_state;

    typedef struct packed {
        logic signed [5:0]  nice;
        logic signed [31:0] rc;
        logic        [5:0]  pri;
    } t_entry;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] rem;
    } t_div_rsp;

    // nearest(x / F), ties away from zero
    function automatic logic signed [PROD_W-1:0] f_round(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] t;
        if (x >= 0) begin
            f_round = (x + FP_HALF) >>> FRACTION_BITS;
        end else begin
            t = (-x + FP_HALF) >>> FRACTION_BITS;
            f_round = -t;
        end
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [PROD_W-1:0] x);
        if (x > PROD_W'(32'sh7fffffff))
            f_sat32 = 32'sh7fffffff;
        else if (x < -PROD_W'(33'sh080000000))
            f_sat32 = 32'sh80000000;
        else
            f_sat32 = x[31:0];
    endfunction

    function automatic logic [5:0] f_calc_pri(input logic signed [31:0] rc,
                                               input logic signed [5:0] nc);
        logic signed [31:0]       q;
        logic signed [PROD_W-1:0] p;
        q = (rc < 0) ? ((rc + 32'sd3) >>> 2) : (rc >>> 2);
        p = PROD_W'(PRIORITY_HIGHEST) - f_round(PROD_W'(q)) - (PROD_W'(nc) <<< 1);
        if (p < PROD_W'(PRIORITY_LOWEST))
            f_calc_pri = 6'(PRIORITY_LOWEST);
        else if (p > PROD_W'(PRIORITY_HIGHEST))
            f_calc_pri = 6'(PRIORITY_HIGHEST);
        else
            f_calc_pri = p[5:0];
    endfunction

endpackage

### hdl/mlfqs_div.sv
// ----------------------------------------------------------------------------
// mlfqs_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mlfqs_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mlfqs_pkg::t_div_req i_req,
    output mlfqs_pkg::t_div_rsp o_rsp
);
    import mlfqs_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quo, r_rem, r_div;
    logic [DIV_W:0]   rem_sh, diff;
    logic             ge;

    always_comb begin
        rem_sh = {r_rem, r_quo[DIV_W-1]};
        diff   = rem_sh - {1'b0, r_div};
        ge     = rem_sh >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_cnt <= CNT_W'(DIV_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DIV_W-2:0], ge};
            r_rem <= ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        end
    end

    assign o_rsp.busy = (r_cnt != '0);
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> o_rsp.busy)
        else $error("divider not busy after start");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.busy |-> !i_req.start)
        else $error("divider restarted while busy");
    a_rem_lt_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_rsp.busy) && r_div != '0) |-> (r_rem < r_div))
        else $error("remainder not below divisor");

endmodule

### hdl/mlfqs_priority_update_top.sv
// ----------------------------------------------------------------------------
// mlfqs_priority_update_top
// Thread slot table with load average, CPU usage decay and priority update.
// ----------------------------------------------------------------------------
// channel   dir  handshake             payload
// s_axis    in   tvalid/tready         tuser: cmd; tdata: request fields
// m_axis    out  tvalid/tready         tuser: status; tdata: slot report
// cfg       in   i_cfg_wr_en           i_cfg_wr_data: mlfqs_enable
//
// On a second boundary a tick also runs reciprocal multiplies, a divide for
// the decay coefficient and a walk over 64 slots, and it walks the slots
// again when priorities are recomputed. The table has no clearing pass:
// reset clears the active bits and inactive slots read as zero.
// s_axis_tready is low from acceptance until the result is in the output
// register; a stalled result holds the block in its last state.
module mlfqs_priority_update_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: slot[5:0], running_idle[6], ready_count[13:7], tick_count[45:14],
    //        nice_value[51:46], parent_slot[57:52]
    input  logic [63:0] s_axis_tdata,
    // tuser: cmd[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: out_slot[5:0], priority_res[11:6], nice[17:12],
    //        cpu_x100[39:18], load_x100[52:40]
    output logic [55:0] m_axis_tdata,
    // tuser: status[0]
    output logic        m_axis_tuser
);
    import mlfqs_pkg::*;

    t_state r_state, n_state;

    logic [1:0]         r_cmd;
    logic [IDX_W-1:0]   r_slot, r_parent, r_idx;
    logic               r_idle, r_en, r_status;
    logic [6:0]         r_ready;
    logic [31:0]        r_ticks, r_tmp;
    logic signed [5:0]  r_nv;
    logic signed [31:0] r_load;
    logic [15:0]        r_coef;
    logic signed [21:0] r_rcx;
    logic [MAX_THREADS-1:0] r_active;
    logic signed [PROD_W-1:0] r_prod;
    logic               r_ovalid, r_ouser;
    logic [55:0]        r_odata;

    t_entry r_mem [MAX_THREADS];
    t_entry r_rd_raw, rd_val, wr_data;
    logic   r_rd_act;
    logic   rd_en, wr_en, mul_en;
    logic [IDX_W-1:0] rd_addr, wr_addr;

    logic signed [32:0]       mul_a;
    logic [31:0]              mul_b;
    logic signed [PROD_W-1:0] mul_p, walk_t, rnd;
    logic signed [5:0]        nv_in;
    logic [7:0]               nready;
    logic [12:0]              loadx;
    logic                     accept, out_go, last_idx;

    t_div_req div_req;
    t_div_rsp div_rsp;

    mlfqs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_go        = !r_ovalid || m_axis_tready;
    assign last_idx      = (r_idx == IDX_W'(MAX_THREADS - 1));
    assign rd_val        = r_rd_act ? r_rd_raw : '0;
    assign nready        = 8'(r_ready) + 8'(!r_idle);
    assign mul_p         = mul_a * $signed({1'b0, mul_b});
    assign nv_in         = s_axis_tdata[51:46];

    // truncate coef*rc/F toward zero
    always_comb begin
        if (r_prod < 0)
            walk_t = (r_prod + (FP_ONE - 1)) >>> FRACTION_BITS;
        else
            walk_t = r_prod >>> FRACTION_BITS;
        rnd = f_round(r_prod);
        if (rnd < 0)
            loadx = '0;
        else if (rnd > PROD_W'(6400))
            loadx = 13'd6400;
        else
            loadx = rnd[12:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) n_state = S_RD;
            S_RD:   n_state = S_EXE;
            S_EXE: begin
                case (t_cmd'(r_cmd))
                    CMD_TICK:   n_state = S_MODT;
                    CMD_CREATE: n_state = r_rd_act ? S_FRD : S_PRA;
                    default:    n_state = S_FRD;
                endcase
            end
            S_PRA:  n_state = S_PRB;
            S_PRB:  n_state = S_FRD;
            S_MODT: n_state = S_MODQ;
            S_MODQ: n_state = S_MODC;
            // second boundary when quotient * TICKS_PER_SECOND gives back the tick number
            S_MODC: n_state = (r_prod[31:0] == r_ticks) ? S_L1 : S_CHKP;
            S_L1:   n_state = S_L1R;
            S_L1R:  n_state = S_L1Q;
            S_L1Q:  n_state = S_L2R;
            S_L2R:  n_state = S_CD;
            S_CD:   n_state = S_CW;
            S_CW:   if (!div_rsp.busy) n_state = S_WA;
            S_WA:   n_state = S_WB;
            S_WB:   n_state = S_WC;
            S_WC:   n_state = last_idx ? S_CHKP : S_WA;
            S_CHKP: n_state = (r_en && (r_ticks % 32'(PRIORITY_PERIOD)) == '0) ? S_QA : S_FRD;
            S_QA:   n_state = S_QB;
            S_QB:   n_state = last_idx ? S_FRD : S_QA;
            S_FRD:  n_state = S_FM1;
            S_FM1:  n_state = S_FM2;
            S_FM2:  n_state = S_OUT;
            S_OUT:  if (out_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_slot;
        wr_en   = 1'b0;
        wr_addr = r_slot;
        wr_data = rd_val;
        div_req = '0;
        mul_en  = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        case (r_state)
            S_RD, S_FRD: rd_en = 1'b1;
            S_EXE: begin
                if (t_cmd'(r_cmd) == CMD_TICK && r_rd_act && !r_idle) begin
                    wr_en      = 1'b1;
                    wr_data.rc = f_sat32(PROD_W'(rd_val.rc) + FP_ONE);
                end
                if (t_cmd'(r_cmd) == CMD_NICE && r_rd_act) begin
                    wr_en        = 1'b1;
                    wr_data.nice = r_nv;
                end
            end
            S_PRA: begin
                rd_en   = 1'b1;
                rd_addr = r_parent;
            end
            // slot is inactive here, so a parent equal to the slot reads as zero
            S_PRB: begin
                wr_en       = 1'b1;
                wr_data.pri = f_calc_pri(rd_val.rc, rd_val.nice);
            end
            S_MODT: begin
                mul_en = 1'b1;
                mul_a  = 33'(r_ticks);
                mul_b  = TPS_RECIP;
            end
            S_MODQ: begin
                mul_en = 1'b1;
                mul_a  = 33'(r_prod[RECIP_SHIFT +: QUO_W]);
                mul_b  = 32'(TICKS_PER_SECOND);
            end
            S_L1: begin
                mul_en = 1'b1;
                mul_a  = 33'(r_load);
                mul_b  = 32'(LOAD_NUM);
            end
            S_L1R: begin
                mul_en = 1'b1;
                mul_a  = 33'(r_prod[31:0]);
                mul_b  = DEN_RECIP;
            end
            S_L1Q: begin
                mul_en = 1'b1;
                mul_a  = 33'(nready) << FRACTION_BITS;
                mul_b  = DEN_RECIP;
            end
            S_CD: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(r_load) << (FRACTION_BITS + 1);
                div_req.divisor  = (DIV_W'(r_load) << 1) + DIV_W'(FP_ONE);
            end
            S_WA, S_QA: begin
                rd_en   = 1'b1;
                rd_addr = r_idx;
            end
            S_WB: begin
                mul_en = 1'b1;
                mul_a  = 33'(rd_val.rc);
                mul_b  = 32'(r_coef);
            end
            S_WC: begin
                wr_en      = r_active[r_idx];
                wr_addr    = r_idx;
                wr_data.rc = f_sat32(walk_t + (PROD_W'(rd_val.nice) <<< FRACTION_BITS));
            end
            S_QB: begin
                wr_en       = r_active[r_idx];
                wr_addr     = r_idx;
                wr_data.pri = f_calc_pri(rd_val.rc, rd_val.nice);
            end
            S_FM1: begin
                mul_en = 1'b1;
                mul_a  = 33'(rd_val.rc);
                mul_b  = 32'd100;
            end
            S_FM2: begin
                mul_en = 1'b1;
                mul_a  = 33'(r_load);
                mul_b  = 32'd100;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_raw <= r_mem[rd_addr];
            r_rd_act <= r_active[rd_addr];
        end
        if (wr_en)
            r_mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_en     <= 1'b0;
            r_load   <= '0;
            r_active <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en)
                r_en <= i_cfg_wr_data;
            // load stays below 129 in fixed point, no saturation needed
            if (r_state == S_L2R)
                r_load <= r_tmp + 32'(r_prod[RECIP_SHIFT +: QUO_W]);
            if (r_state == S_PRB)
                r_active[r_slot] <= 1'b1;
            if (r_state == S_OUT && out_go && t_cmd'(r_cmd) == CMD_RETIRE && !r_status)
                r_active[r_slot] <= 1'b0;
            if (r_state == S_OUT && out_go)
                r_ovalid <= 1'b1;
            else if (m_axis_tready)
                r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= s_axis_tuser;
            r_slot   <= s_axis_tdata[5:0];
            r_idle   <= s_axis_tdata[6];
            r_ready  <= s_axis_tdata[13:7];
            r_ticks  <= s_axis_tdata[45:14];
            r_parent <= s_axis_tdata[57:52];
            if (nv_in < -6'sd20)
                r_nv <= -6'sd20;
            else if (nv_in > 6'sd20)
                r_nv <= 6'sd20;
            else
                r_nv <= nv_in;
        end
        if (r_state == S_EXE)
            r_status <= (t_cmd'(r_cmd) == CMD_CREATE) ? r_rd_act : !r_rd_act;
        if (mul_en)
            r_prod <= mul_p;
        if (r_state == S_L1Q)
            r_tmp <= 32'(r_prod[RECIP_SHIFT +: QUO_W]);
        if (r_state == S_CW && !div_rsp.busy)
            r_coef <= div_rsp.quo[15:0];
        if (r_state == S_CW || r_state == S_CHKP)
            r_idx <= '0;
        else if (r_state == S_WC || r_state == S_QB)
            r_idx <= r_idx + 1'b1;
        if (r_state == S_FM2) begin
            if (rnd > PROD_W'(2000000))
                r_rcx <= 22'sd2000000;
            else if (rnd < -PROD_W'(2000000))
                r_rcx <= -22'sd2000000;
            else
                r_rcx <= rnd[21:0];
        end
        if (r_state == S_OUT && out_go) begin
            r_ouser <= r_status;
            r_odata <= {3'b000, loadx, r_rcx, rd_val.nice, rd_val.pri, r_slot};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !s_axis_tready)
        else $error("ready after accepting a request");
    a_coef_below_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB) |-> (r_coef < 16'(FP_ONE)))
        else $error("decay coefficient not below one");
    a_load_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_load[31])
        else $error("load average negative");
    a_div_idle_at_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FRD) |-> !div_rsp.busy)
        else $error("divider busy at report");

endmodule

### test/tb_mlfqs_priority_update_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mlfqs_priority_update_top
// Self-checking bench: random and directed scheduler requests, a shadow slot
// table predicts every slot report, checked field by field in order.
// ----------------------------------------------------------------------------
import mlfqs_pkg::*;

typedef struct packed {
    logic              status;
    logic [5:0]        slot;
    logic [5:0]        pri;
    logic signed [5:0] nice;
    logic [21:0]       rc100;
    logic [12:0]       load100;
} t_report;

class sched_scoreboard;
    bit                 act [64];
    int                 nice_tbl [64];
    int                 rc_tbl [64];
    int                 pri_tbl [64];
    int                 sys_load;
    bit                 prio_en;
    t_report            pending [$];
    int                 errors;

    function new();
        errors = 0;
        sys_load = 0;
        prio_en = 0;
        for (int i = 0; i < 64; i++) begin
            act[i] = 0; nice_tbl[i] = 0; rc_tbl[i] = 0; pri_tbl[i] = 0;
        end
    endfunction

    function longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function longint nearest(longint x);
        longint f;
        f = longint'(1) << FRACTION_BITS;
        if (x >= 0) return (x + f / 2) / f;
        return (x - f / 2) / f;
    endfunction

    function int prio_of(int rc, int nc);
        longint p;
        p = PRIORITY_HIGHEST - nearest(longint'(rc) / 4) - 2 * longint'(nc);
        if (p < PRIORITY_LOWEST) p = PRIORITY_LOWEST;
        if (p > PRIORITY_HIGHEST) p = PRIORITY_HIGHEST;
        return int'(p);
    endfunction

    // note an accepted request and queue the predicted report
    function void note_request(t_cmd cmd, logic [63:0] d);
        int s, ps, nv, rn, rr, rp;
        bit idle, active;
        int unsigned ready, ticks;
        longint f, twol, coef, v;
        t_report r;
        f = longint'(1) << FRACTION_BITS;
        s = d[5:0]; idle = d[6]; ready = d[13:7]; ticks = d[45:14];
        nv = $signed(d[51:46]); ps = d[57:52];
        if (nv < -20) nv = -20;
        if (nv > 20) nv = 20;
        active = act[s];
        r.status = !active;
        case (cmd)
            CMD_TICK: begin
                if (active && !idle) rc_tbl[s] = int'(sat32(longint'(rc_tbl[s]) + f));
                if (ticks % TICKS_PER_SECOND == 0) begin
                    sys_load = int'(sat32(longint'(sys_load) * 59 / 60
                                          + (longint'(ready) + (idle ? 0 : 1)) * f / 60));
                    twol = 2 * longint'(sys_load);
                    coef = (twol + f > 0) ? twol * f / (twol + f) : 0;
                    for (int i = 0; i < 64; i++)
                        if (act[i])
                            rc_tbl[i] = int'(sat32(coef * longint'(rc_tbl[i]) / f
                                                   + longint'(nice_tbl[i]) * f));
                end
                if (prio_en && ticks % PRIORITY_PERIOD == 0)
                    for (int i = 0; i < 64; i++)
                        if (act[i]) pri_tbl[i] = prio_of(rc_tbl[i], nice_tbl[i]);
            end
            CMD_NICE: if (active) nice_tbl[s] = nv;
            CMD_CREATE: begin
                if (active) r.status = 1;
                else begin
                    bit pa;
                    pa = (ps != s) && act[ps];
                    act[s] = 1;
                    nice_tbl[s] = pa ? nice_tbl[ps] : 0;
                    rc_tbl[s] = pa ? rc_tbl[ps] : 0;
                    pri_tbl[s] = prio_of(rc_tbl[s], nice_tbl[s]);
                    r.status = 0;
                end
            end
            default: ;
        endcase
        rn = nice_tbl[s]; rr = rc_tbl[s]; rp = pri_tbl[s];
        if (cmd == CMD_RETIRE && active) begin
            act[s] = 0; nice_tbl[s] = 0; rc_tbl[s] = 0; pri_tbl[s] = 0;
        end
        r.slot = s; r.pri = rp[5:0]; r.nice = rn[5:0];
        v = nearest(longint'(rr) * 100);
        if (v > 2000000) v = 2000000;
        if (v < -2000000) v = -2000000;
        r.rc100 = v[21:0];
        v = nearest(longint'(sys_load) * 100);
        if (v > 6400) v = 6400;
        if (v < 0) v = 0;
        r.load100 = v[12:0];
        pending.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task check_report(logic st, logic [55:0] d);
        t_report e;
        if (pending.size() == 0) begin
            report("unexpected report", d[31:0], 0);
            return;
        end
        e = pending.pop_front();
        if (st != e.status) report("status", st, e.status);
        if (d[5:0] != e.slot) report("slot", d[5:0], e.slot);
        if (d[11:6] != e.pri) report("priority", d[11:6], e.pri);
        if (d[17:12] != e.nice) report("nice", d[17:12], e.nice);
        if (d[39:18] != e.rc100) report("cpu_x100", d[39:18], e.rc100);
        if (d[52:40] != e.load100) report("load_x100", d[52:40], e.load100);
    endtask
endclass

module tb_mlfqs_priority_update_top;
    logic        i_clk, i_rst_n;
    logic        i_cfg_wr_en, i_cfg_wr_data;
    logic        s_axis_tvalid, s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid, m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;

    sched_scoreboard sb;
    bit          idle_src, idle_snk, hold_snk;
    int unsigned tick_no;

    mlfqs_priority_update_top dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("FAIL mlfqs_priority_update_top");
        $finish;
    end

    // sink: random backpressure, checks at accepted edges
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_report(m_axis_tuser, m_axis_tdata);
        m_axis_tready <= !hold_snk && !(idle_snk && $urandom_range(99) < 24);
    end

    task automatic send(t_cmd cmd, logic [5:0] s, logic idle, logic [6:0] ready,
                        logic [31:0] ticks, logic [5:0] nv, logic [5:0] ps);
        logic [63:0] d;
        d = {6'd0, ps, nv, ticks, ready, idle, s};
        while (idle_src && $urandom_range(99) < 24) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= d;
        s_axis_tuser <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(cmd, d);
    endtask

    task automatic tick(logic [5:0] s, logic idle, logic [6:0] ready);
        tick_no++;
        send(CMD_TICK, s, idle, ready, tick_no, 6'($urandom), 6'($urandom));
    endtask

    task automatic drain_and_cfg(bit en);
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        i_cfg_wr_en <= 1;
        i_cfg_wr_data <= en;
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
        sb.prio_en = en;
    endtask

    task automatic random_item();
        int k;
        logic [5:0] s;
        s = $urandom_range(99) < 80 ? 6'($urandom_range(11)) : 6'($urandom);
        k = $urandom_range(99);
        if (k < 55) begin
            // occasionally land on a second boundary or a wild tick number
            if ($urandom_range(9) == 0) tick_no = tick_no + 99 - tick_no % 100;
            if ($urandom_range(30) == 0) tick_no = $urandom;
            tick(s, $urandom_range(4) == 0, $urandom_range(9) == 0 ? 7'($urandom) :
                 7'($urandom_range(64)));
        end else if (k < 70)
            send(CMD_NICE, s, 1'($urandom), 7'($urandom), $urandom, 6'($urandom),
                 6'($urandom));
        else if (k < 88)
            send(CMD_CREATE, s, 1'($urandom), 7'($urandom), $urandom, 6'($urandom),
                 $urandom_range(1) ? 6'($urandom_range(11)) : 6'($urandom));
        else
            send(CMD_RETIRE, s, 1'($urandom), 7'($urandom), $urandom, 6'($urandom),
                 6'($urandom));
    endtask

    initial begin
        sb = new();
        i_rst_n = 0; i_cfg_wr_en = 0; i_cfg_wr_data = 0;
        s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = CMD_TICK;
        m_axis_tready = 0; idle_src = 0; idle_snk = 0; hold_snk = 0;
        tick_no = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: inactive slot commands, creates, nice extremes, retire
        send(CMD_NICE, 6'd3, 0, 0, 0, 6'd5, 0);
        send(CMD_RETIRE, 6'd63, 0, 0, 0, 0, 0);
        tick(6'd0, 0, 7'd0);
        send(CMD_CREATE, 6'd0, 0, 0, 0, 0, 6'd0);
        send(CMD_CREATE, 6'd0, 0, 0, 0, 0, 6'd1);
        send(CMD_NICE, 6'd0, 0, 0, 0, 6'b011111, 0);
        send(CMD_CREATE, 6'd1, 0, 0, 0, 0, 6'd0);
        send(CMD_NICE, 6'd1, 0, 0, 0, 6'b100000, 0);
        send(CMD_CREATE, 6'd63, 0, 0, 0, 0, 6'd1);
        send(CMD_NICE, 6'd63, 0, 0, 0, 6'sd7, 0);
        tick_no = 99;
        tick(6'd0, 0, 7'd127);
        tick(6'd1, 1, 7'd64);
        drain_and_cfg(1);
        for (int i = 0; i < 8; i++) tick(6'd63, i[0], 7'd5);
        tick_no = 32'hFFFF_FFFE;
        tick(6'd0, 0, 7'd0);
        tick(6'd0, 0, 7'd0);
        send(CMD_RETIRE, 6'd1, 0, 0, 0, 0, 0);
        send(CMD_CREATE, 6'd1, 0, 0, 0, 0, 6'd0);
        tick_no = 0;

        // random, no idling first
        for (int i = 0; i < 60; i++) random_item();
        idle_src = 1; idle_snk = 1;
        for (int i = 0; i < 70; i++) random_item();
        drain_and_cfg(0);
        fork
            begin
                hold_snk = 1;
                repeat (2000) @(posedge i_clk);
                hold_snk = 0;
            end
            for (int i = 0; i < 40; i++) random_item();
        join
        drain_and_cfg(1);
        for (int i = 0; i < 100; i++) random_item();

        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        if (sb.errors == 0)
            $display("PASS mlfqs_priority_update_top");
        else
            $display("FAIL mlfqs_priority_update_top");
        $finish;
    end
endmodule
